// ===== sv/kfsi_pkg.sv =====
// package: types, constants and helpers for the keyframe scale interpolator
`timescale 1ns / 1ps
package kfsi_pkg;
    localparam int MAX_KEYFRAMES = 16;
    localparam int IDX_W = $clog2(MAX_KEYFRAMES);
    localparam int CNT_W = $clog2(MAX_KEYFRAMES + 1);

    typedef enum logic [1:0] {
        REQ_EVAL   = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_SRCH_W,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_EV_RD,
        S_EV_W,
        S_DIV,
        S_MIX,
        S_SIZE,
        S_OUT
    } state_t;

    // memory port request from the sequencer
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [31:0]       wtime;
        logic [15:0]       wscale;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

    function automatic logic [15:0] sat_size(input logic [32:0] v);
        logic [24:0] s;
        s = v[32:8];
        return (s > 25'h00FFFF) ? 16'hFFFF : s[15:0];
    endfunction
endpackage

// ===== sv/kfsi_mem.sv =====
// keyframe table: time and scale memory with registered read
`timescale 1ns / 1ps
module kfsi_mem (
    input  logic                  aclk,
    input  kfsi_pkg::mem_req_t    req,
    output logic [31:0]           rd_time,
    output logic [15:0]           rd_scale
);
    import kfsi_pkg::*;

    logic [47:0] mem_reg [MAX_KEYFRAMES];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem_reg[req.waddr] <= {req.wtime, req.wscale};
        end
        rd_time  <= mem_reg[req.raddr][47:16];
        rd_scale <= mem_reg[req.raddr][15:0];
    end
endmodule

// ===== sv/kfsi_div.sv =====
// restoring divider: 48-bit dividend over 32-bit divisor, one quotient bit a cycle
`timescale 1ns / 1ps
module kfsi_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [47:0] quotient
);
    import kfsi_pkg::*;

    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [47:0] q_reg;
    logic [31:0] d_reg;
    logic [32:0] trial;
    logic        ge;

    assign trial = {rem_reg, q_reg[47]};
    assign ge = trial >= {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= 6'd48;
        end else if (cnt_reg != 6'd0) begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            q_reg   <= dividend;
            d_reg   <= divisor;
        end else if (cnt_reg != 6'd0) begin
            rem_reg <= ge ? 32'(trial - {1'b0, d_reg}) : trial[31:0];
            q_reg   <= {q_reg[46:0], ge};
        end
    end

    assign busy = cnt_reg != 6'd0;
    assign quotient = q_reg;
endmodule

// ===== sv/kfsi_ctrl.sv =====
// sequencer: search, shift, interpolation and result register
`timescale 1ns / 1ps
module kfsi_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_req_type,
    input  logic [31:0]          s_seg_time,
    input  logic [15:0]          s_seg_scale,
    input  logic [31:0]          s_total_life,
    input  logic [31:0]          s_remaining_life,
    input  logic [15:0]          s_init_width,
    input  logic [15:0]          s_init_height,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic [3:0]           m_position,
    output logic [15:0]          m_scaled_width,
    output logic [15:0]          m_scaled_height,
    output kfsi_pkg::mem_req_t   mreq,
    input  logic [31:0]          rd_time,
    input  logic [15:0]          rd_scale,
    output logic                 div_start,
    output logic [47:0]          div_dividend,
    output logic [31:0]          div_divisor,
    input  logic                 div_busy,
    input  logic [47:0]          div_quot
);
    import kfsi_pkg::*;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;      // search / shift index
    logic [CNT_W-1:0] pos_reg, pos_next;      // found position
    req_t        req_reg;
    logic [31:0] time_reg, age_reg;
    logic [15:0] scale_reg, w_reg, h_reg;
    logic [31:0] t0_reg, t1_reg;
    logic [15:0] s0_reg, s1_reg;
    logic [16:0] frac_reg;
    logic [15:0] mix_reg;
    logic        mval_reg;
    logic [1:0]  mst_reg;
    logic [3:0]  mpos_reg;
    logic [15:0] mw_reg, mh_reg;
    logic [1:0]  res_st_reg;
    logic [3:0]  res_pos_reg;
    logic [15:0] res_w_reg, res_h_reg;
    logic        accept, done_srch, hit, out_load;
    logic [33:0] mix_sum;
    logic [32:0] pw, ph;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    // finished item moves to the output register once that is free
    assign out_load = (state_reg == S_OUT) && (!mval_reg || m_ready);

    // search: evaluate stops at first age <= t, insert at first t >= key, delete at ==
    always_comb begin
        unique case (req_reg)
            REQ_EVAL:   hit = age_reg <= rd_time;
            REQ_INSERT: hit = rd_time >= time_reg;
            REQ_DELETE: hit = rd_time == time_reg;
            default:    hit = 1'b1;
        endcase
    end
    assign done_srch = hit || (idx_reg + 1'b1 >= cnt_reg);

    assign mix_sum = 34'(s1_reg) * 34'(frac_reg)
                   + 34'(s0_reg) * 34'(17'h10000 - frac_reg) + 34'd32768;
    assign pw = 33'(w_reg) * 33'(mix_reg) + 33'd128;
    assign ph = 33'(h_reg) * 33'(mix_reg) + 33'd128;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) begin
                priority if (s_req_type == REQ_NONE) state_next = S_OUT;
                else if (cnt_reg == '0) state_next = (s_req_type == REQ_INSERT) ? S_PUT : S_OUT;
                else state_next = S_SRCH;
            end
            S_SRCH:   state_next = S_SRCH_W;
            S_SRCH_W: begin
                if (!done_srch) state_next = S_SRCH;
                else begin
                    unique case (req_reg)
                        REQ_EVAL:   state_next = S_EV_RD;
                        REQ_INSERT: begin
                            priority if (hit && rd_time == time_reg) state_next = S_PUT;
                            else if (cnt_reg == CNT_W'(MAX_KEYFRAMES)) state_next = S_OUT;
                            else state_next = S_SHIFT_RD;
                        end
                        default: state_next = hit ? S_SHIFT_RD : S_OUT;
                    endcase
                end
            end
            S_SHIFT_RD: state_next = S_SHIFT_WR;
            S_SHIFT_WR: begin
                if (req_reg == REQ_INSERT)
                    state_next = (idx_reg == pos_reg) ? S_PUT : S_SHIFT_RD;
                else
                    state_next = (idx_reg + 1'b1 >= cnt_reg) ? S_OUT : S_SHIFT_RD;
            end
            S_PUT:   state_next = S_OUT;
            S_EV_RD: state_next = S_EV_W;
            S_EV_W:  state_next = S_DIV;
            S_DIV:   if (!div_busy && !div_start) state_next = S_MIX;
            S_MIX:   state_next = S_SIZE;
            S_SIZE:  state_next = S_OUT;
            S_OUT:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // memory and divider controls
    always_comb begin
        mreq = '0;
        mreq.raddr = idx_reg[IDX_W-1:0];
        div_start = 1'b0;
        div_dividend = {(age_reg > t0_reg) ? age_reg - t0_reg : 32'd0, 16'd0};
        div_divisor = t1_reg - t0_reg;
        unique case (state_reg)
            S_SHIFT_RD: mreq.raddr = (req_reg == REQ_INSERT) ? IDX_W'(idx_reg - 1'b1)
                                                             : IDX_W'(idx_reg + 1'b1);
            S_SHIFT_WR: begin
                mreq.we = 1'b1;
                mreq.waddr = IDX_W'(idx_reg);
                mreq.wtime = rd_time;
                mreq.wscale = rd_scale;
            end
            S_PUT: begin
                mreq.we = 1'b1;
                mreq.waddr = IDX_W'(pos_reg);
                mreq.wtime = time_reg;
                mreq.wscale = scale_reg;
            end
            S_EV_RD: mreq.raddr = IDX_W'(pos_reg - 1'b1);
            S_DIV:   div_start = (t1_reg > t0_reg) && (frac_reg == 17'h1FFFF);
            default: ;
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        pos_next = pos_reg;
        unique case (state_reg)
            S_IDLE:     begin idx_next = '0; pos_next = '0; end
            S_SRCH_W: begin
                if (!done_srch) idx_next = idx_reg + 1'b1;
                else begin
                    pos_next = hit ? idx_reg : idx_reg + 1'b1;
                    if (req_reg == REQ_INSERT) idx_next = cnt_reg;
                end
            end
            S_SHIFT_WR: begin
                // insert stops at the target slot so the put sees idx == pos
                if (req_reg != REQ_INSERT) idx_next = idx_reg + 1'b1;
                else if (idx_reg != pos_reg) idx_next = idx_reg - 1'b1;
            end
            S_PUT:      if (req_reg == REQ_INSERT && pos_reg == idx_reg) cnt_next = cnt_reg + 1'b1;
            default: ;
        endcase
        if (state_reg == S_SRCH_W && done_srch && req_reg == REQ_DELETE && hit)
            cnt_next = cnt_reg - 1'b1;
        if (state_reg == S_SRCH_W && done_srch && req_reg == REQ_INSERT
            && hit && rd_time == time_reg)
            idx_next = '1;
        if (state_reg == S_IDLE && accept && s_req_type == REQ_INSERT && cnt_reg == '0)
            idx_next = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_load) mval_reg <= 1'b1;
            else if (m_ready) mval_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        pos_reg <= pos_next;
        if (accept) begin
            req_reg   <= req_t'(s_req_type);
            time_reg  <= s_seg_time;
            scale_reg <= s_seg_scale;
            age_reg   <= (s_remaining_life > s_total_life) ? 32'd0
                                                           : s_total_life - s_remaining_life;
            w_reg     <= s_init_width;
            h_reg     <= s_init_height;
            mst_reg   <= ((s_req_type == REQ_EVAL || s_req_type == REQ_DELETE)
                          && cnt_reg == '0) ? ST_EMPTY : ST_DONE;
            mpos_reg  <= '0;
            mw_reg    <= '0;
            mh_reg    <= '0;
        end
        if (state_reg == S_SRCH_W) begin
            if (done_srch) begin
                t1_reg <= rd_time;
                s1_reg <= rd_scale;
                if (req_reg == REQ_DELETE && !hit) mst_reg <= ST_NOTFOUND;
                else if (req_reg == REQ_INSERT && !(hit && rd_time == time_reg)
                         && cnt_reg == CNT_W'(MAX_KEYFRAMES)) mst_reg <= ST_FULL;
                else mpos_reg <= 4'(hit ? idx_reg : idx_reg + 1'b1);
            end
        end
        if (state_reg == S_EV_W) begin
            // first / last clamp or bracket setup
            if (pos_reg == '0 || cnt_reg == CNT_W'(1)) begin
                s0_reg <= s1_reg; t0_reg <= t1_reg; frac_reg <= 17'h10000;
                mpos_reg <= '0;
            end else if (pos_reg >= cnt_reg) begin
                s0_reg <= s1_reg; t0_reg <= t1_reg; frac_reg <= 17'h10000;
                mpos_reg <= 4'(cnt_reg - 1'b1);
            end else begin
                t0_reg <= rd_time;
                s0_reg <= rd_scale;
                frac_reg <= 17'h1FFFF;
            end
        end
        if (state_reg == S_DIV && frac_reg == 17'h1FFFF && t1_reg <= t0_reg
            && !div_start)
            frac_reg <= 17'h10000;
        if (state_reg == S_DIV && div_start)
            frac_reg <= 17'h1FFFE;
        if (state_reg == S_DIV && !div_busy && frac_reg == 17'h1FFFE && !div_start)
            frac_reg <= (div_quot > 48'h10000) ? 17'h10000 : div_quot[16:0];
        if (state_reg == S_MIX) mix_reg <= mix_sum[31:16];
        if (state_reg == S_SIZE) begin
            mw_reg <= sat_size(pw);
            mh_reg <= sat_size(ph);
        end
        if (out_load) begin
            res_st_reg  <= mst_reg;
            res_pos_reg <= mpos_reg;
            res_w_reg   <= mw_reg;
            res_h_reg   <= mh_reg;
        end
    end

    assign m_valid = mval_reg;
    assign m_status = res_st_reg;
    assign m_position = res_pos_reg;
    assign m_scaled_width = res_w_reg;
    assign m_scaled_height = res_h_reg;

`ifndef ASSERT_OFF
    a_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_KEYFRAMES)) else $error("entry count overflow");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready) else $error("ready while busy");
    a_out_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) |=> m_valid) else $error("result lost");
`endif
endmodule

// ===== sv/keyframe_scale_interpolator_core.sv =====
// top level: keyframe scale interpolator
`timescale 1ns / 1ps
// requests search the table entry by entry; an insert moves later entries up before the put
// (an overwrite puts at once, a full table does not), a delete moves later entries down
// (at least one; a miss does not), evaluate clamps or interpolates (bit-serial fraction
// divider); type 3 and empty-table requests skip the search, an empty-table insert puts
// throughput: one item at a time, next accept the cycle after the result registers;
// reset: synchronous active-low aresetn clears count and handshake
module keyframe_scale_interpolator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [31:0] s_seg_time,
    input  logic [15:0] s_seg_scale,
    input  logic [31:0] s_total_life,
    input  logic [31:0] s_remaining_life,
    input  logic [15:0] s_init_width,
    input  logic [15:0] s_init_height,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [3:0]  m_position,
    output logic [15:0] m_scaled_width,
    output logic [15:0] m_scaled_height
);
    import kfsi_pkg::*;

    mem_req_t    mreq;
    logic [31:0] rd_time;
    logic [15:0] rd_scale;
    logic        div_start, div_busy;
    logic [47:0] div_dividend, div_quot;
    logic [31:0] div_divisor;

    // keyframe storage, sorted by time
    kfsi_mem u_mem (
        .aclk(aclk), .req(mreq), .rd_time(rd_time), .rd_scale(rd_scale)
    );

    // fraction divider for interpolation
    kfsi_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_dividend),
        .divisor(div_divisor), .busy(div_busy), .quotient(div_quot)
    );

    // request sequencer, with a result register that frees the input side
    kfsi_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_seg_time(s_seg_time), .s_seg_scale(s_seg_scale),
        .s_total_life(s_total_life), .s_remaining_life(s_remaining_life),
        .s_init_width(s_init_width), .s_init_height(s_init_height),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_position(m_position), .m_scaled_width(m_scaled_width),
        .m_scaled_height(m_scaled_height),
        .mreq(mreq), .rd_time(rd_time), .rd_scale(rd_scale),
        .div_start(div_start), .div_dividend(div_dividend), .div_divisor(div_divisor),
        .div_busy(div_busy), .div_quot(div_quot)
    );
endmodule
